// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dsa_pkg.sv =====
`timescale 1ns / 1ps
package dsa_pkg;

  // fixed field widths
  localparam int ADDR_W    = 48;
  localparam int STRIDE_W  = 13;
  localparam int CAP_W     = 11;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  // build defaults
  localparam int DEF_SLOT_DEPTH  = 1024;
  localparam int DEF_FRAME_COUNT = 3;

  // register reset values
  localparam logic [CAP_W-1:0]    RST_CAPACITY = CAP_W'(1024);
  localparam logic [STRIDE_W-1:0] RST_STRIDE   = STRIDE_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 3'd0,
    ST_FULL = 3'd1,
    ST_NONE = 3'd2,
    ST_BAD  = 3'd3,
    ST_NULL = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 3'd0,
    REG_SHADER   = 3'd1,
    REG_STRIDE   = 3'd2,
    REG_CPU_BASE = 3'd3,
    REG_GPU_BASE = 3'd4
  } cfg_reg_t;

  // width of a frame number
  function automatic int frame_width(int n);
    return (n < 2) ? 1 : $clog2(n);
  endfunction

endpackage

// ===== hw/rtl/dsa_if.sv =====
`timescale 1ns / 1ps

// request channel
interface dsa_req_if import dsa_pkg::*; #(
  parameter int FSW = 2
) ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] cpu_handle;
  logic [FSW-1:0]    frame_slot;

  modport source(output valid, operation, cpu_handle, frame_slot, input ready);
  modport sink(input valid, operation, cpu_handle, frame_slot, output ready);
endinterface

// response channel
interface dsa_rsp_if import dsa_pkg::*; #(
  parameter int IW = 10
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IW-1:0]       slot_index;
  logic [ADDR_W-1:0]   cpu_address;
  logic [ADDR_W-1:0]   gpu_address;

  modport source(output valid, status, slot_index, cpu_address, gpu_address, input ready);
  modport sink(input valid, status, slot_index, cpu_address, gpu_address, output ready);
endinterface

// register write channel
interface dsa_cfg_if import dsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dsa_divider.sv =====
`timescale 1ns / 1ps
module dsa_divider import dsa_pkg::*; #(
  parameter int QW = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [STRIDE_W+QW-1:0] dividend,
  input  logic [STRIDE_W-1:0]    divisor,
  output logic                   done,
  output logic [QW-1:0]          quotient,
  output logic                   rem_zero
);
  localparam int SW = $clog2(QW + 1);

  logic              running;
  logic [SW-1:0]     cnt;
  logic [STRIDE_W-1:0] rem;
  logic [QW-1:0]     low;
  logic [STRIDE_W-1:0] dsr;
  logic [STRIDE_W:0] trial;
  logic [STRIDE_W:0] sub;
  logic              ge;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, low[QW-1]};
    sub   = trial - {1'b0, dsr};
    ge    = trial >= {1'b0, dsr};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= SW'(QW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath, dividend high part is below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[STRIDE_W+QW-1:QW];
      low <= dividend[QW-1:0];
      dsr <= divisor;
    end else if (running) begin
      rem <= ge ? sub[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
      low <= {low[QW-2:0], ge};
    end
  end

  assign quotient = low;
  assign rem_zero = (rem == '0);
endmodule

// ===== hw/rtl/descriptor_slot_allocator.sv =====
`timescale 1ns / 1ps
// Descriptor slot allocator: hands out fixed-size slots from a free-index stack.
// req carries operation, cpu_handle and frame_slot; one response per transaction
// on rsp (status, slot_index, cpu_address, gpu_address). cfg writes registers
// 0..4 (capacity, shader visible, stride, cpu base, gpu base) and is always
// ready; write it only while the block is idle.
// One request is in flight at a time; req is ready only when the controller is
// idle. Paths from acceptance to the done state: allocate reads the stack top,
// multiplies and adds; heap full goes straight to done; free checks for a null,
// frame, count, base or range reject, else runs the bit-serial divider with
// QW = clog2(SLOT_DEPTH+1); release does one memory read and one write per
// parked slot; init refills the free stack one entry per cycle.
// A finished response waits in an output register; while rsp is stalled the
// next request can still be taken, and its result waits until the register
// empties. Reset restores register defaults, empties counts and the output;
// the free stack holds nothing usable until the first init.
module descriptor_slot_allocator import dsa_pkg::*; #(
  parameter int SLOT_DEPTH  = DEF_SLOT_DEPTH,
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input logic      clk,
  input logic      rst,
  dsa_req_if.sink  req,
  dsa_rsp_if.source rsp,
  dsa_cfg_if.sink  cfg
);
  `include "assert_macros.svh"

  localparam int IW  = $clog2(SLOT_DEPTH);
  localparam int CW  = $clog2(SLOT_DEPTH + 1);
  localparam int FSW = frame_width(FRAME_COUNT);
  localparam int LW  = CW + STRIDE_W;
  localparam int PW  = IW + STRIDE_W;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_ALLOC_MUL = 10'b0000000010,
    S_ALLOC_ADD = 10'b0000000100,
    S_FREE_CHK  = 10'b0000001000,
    S_FREE_DIV  = 10'b0000010000,
    S_REL_RD    = 10'b0000100000,
    S_REL_WR    = 10'b0001000000,
    S_INIT      = 10'b0010000000,
    S_DONE      = 10'b0100000000,
    S_SPARE     = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [CAP_W-1:0]    capacity_in_use;
  logic                shader_visible;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   cpu_base;
  logic [ADDR_W-1:0]   gpu_base;

  // request fields held for the whole operation
  logic [ADDR_W-1:0] handle_q;
  logic [FSW-1:0]    frame_q;
  logic [ADDR_W:0]   diff_q;
  logic [LW-1:0]     limit_q;
  logic [PW-1:0]     prod_q;
  logic [IW-1:0]     idx_q;

  // counts
  logic [CW-1:0] used_count;
  logic [CW-1:0] total_parked;
  logic [CW-1:0] pcount [FRAME_COUNT];
  logic [CW-1:0] step_cnt;

  // memories
  logic [IW-1:0] free_mem [SLOT_DEPTH];
  logic [IW-1:0] parked_mem [FRAME_COUNT][SLOT_DEPTH];
  logic [IW-1:0] free_rd;
  logic [IW-1:0] parked_rd;

  // result being built and output register
  status_t           res_status;
  logic [IW-1:0]     res_index;
  logic [ADDR_W-1:0] res_cpu;
  logic [ADDR_W-1:0] res_gpu;
  logic              rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [IW-1:0]     rsp_index;
  logic [ADDR_W-1:0] rsp_cpu;
  logic [ADDR_W-1:0] rsp_gpu;

  // divider
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_quot;
  logic          div_rem_zero;

  logic [CW-1:0]     cap_eff;
  logic              frame_ok;
  logic [FSW-1:0]    frame_idx;
  logic [CW-1:0]     pcount_sel;
  logic [CW-1:0]     used_minus1;
  logic [PW-1:0]     mult;
  logic [ADDR_W-1:0] off_ext;
  logic              fm_we;
  logic [IW-1:0]     fm_waddr;
  logic [IW-1:0]     fm_wdata;
  logic              pm_we;

  // shared decode
  always_comb begin
    if (int'(capacity_in_use) > SLOT_DEPTH) cap_eff = CW'(SLOT_DEPTH);
    else cap_eff = CW'(capacity_in_use);
    frame_ok    = int'(frame_q) < FRAME_COUNT;
    frame_idx   = frame_ok ? frame_q : '0;
    pcount_sel  = pcount[frame_idx];
    used_minus1 = used_count - 1'b1;
    mult        = {{STRIDE_W{1'b0}}, free_rd} * {{IW{1'b0}}, slot_stride};
    off_ext     = {{(ADDR_W-PW){1'b0}}, prod_q};
    fm_we       = (state == S_INIT && step_cnt != cap_eff) || state == S_REL_WR;
    fm_waddr    = (state == S_INIT) ? step_cnt[IW-1:0] : used_minus1[IW-1:0];
    fm_wdata    = (state == S_INIT) ? step_cnt[IW-1:0] : parked_rd;
    pm_we       = state == S_FREE_DIV && div_done && div_rem_zero;
  end

  // free stack memory, read at the top of the stack
  always_ff @(posedge clk) begin
    if (fm_we) free_mem[fm_waddr] <= fm_wdata;
    free_rd <= free_mem[used_count[IW-1:0]];
  end

  // per-frame parked lists
  always_ff @(posedge clk) begin
    if (pm_we) parked_mem[frame_idx][pcount_sel[IW-1:0]] <= div_quot[IW-1:0];
    parked_rd <= parked_mem[frame_idx][step_cnt[IW-1:0]];
  end

  dsa_divider #(.QW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_q[LW-1:0]),
    .divisor  (slot_stride),
    .done     (div_done),
    .quotient (div_quot),
    .rem_zero (div_rem_zero)
  );

  // register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= RST_CAPACITY;
      shader_visible  <= 1'b0;
      slot_stride     <= RST_STRIDE;
      cpu_base        <= '0;
      gpu_base        <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CAPACITY: capacity_in_use <= cfg.data[CAP_W-1:0];
        REG_SHADER:   shader_visible  <= cfg.data[0];
        REG_STRIDE:   slot_stride     <= cfg.data[STRIDE_W-1:0];
        REG_CPU_BASE: cpu_base        <= cfg.data;
        REG_GPU_BASE: gpu_base        <= cfg.data;
        default:      ;
      endcase
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_count   <= '0;
      total_parked <= '0;
      step_cnt     <= '0;
      div_start    <= 1'b0;
      rsp_valid    <= 1'b0;
      for (int f = 0; f < FRAME_COUNT; f++) pcount[f] <= '0;
    end else begin
      div_start <= 1'b0;
      // output register drains unless the done state refills it this cycle
      if (rsp_valid && rsp.ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            handle_q   <= req.cpu_handle;
            frame_q    <= req.frame_slot;
            diff_q     <= {1'b0, req.cpu_handle} - {1'b0, cpu_base};
            limit_q    <= {{STRIDE_W{1'b0}}, cap_eff} * {{CW{1'b0}}, slot_stride};
            step_cnt   <= '0;
            res_status <= ST_OK;
            res_index  <= '0;
            res_cpu    <= '0;
            res_gpu    <= '0;
            case (op_t'(req.operation))
              OP_ALLOC: begin
                if (used_count >= cap_eff) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_ALLOC_MUL;
                end
              end
              OP_FREE:    state <= S_FREE_CHK;
              OP_RELEASE: state <= S_REL_RD;
              OP_INIT:    state <= S_INIT;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_ALLOC_MUL: begin
          idx_q  <= free_rd;
          prod_q <= mult;
          state  <= S_ALLOC_ADD;
        end
        S_ALLOC_ADD: begin
          res_index  <= idx_q;
          res_cpu    <= cpu_base + off_ext;
          res_gpu    <= shader_visible ? gpu_base + off_ext : '0;
          used_count <= used_count + 1'b1;
          state      <= S_DONE;
        end
        S_FREE_CHK: begin
          state <= S_DONE;
          if (handle_q == '0) begin
            res_status <= ST_NULL;
          end else if (!frame_ok) begin
            res_status <= ST_BAD;
          end else if (total_parked >= used_count) begin
            res_status <= ST_NONE;
          end else if (slot_stride == '0 || diff_q[ADDR_W]) begin
            res_status <= ST_BAD;
          end else if (diff_q[ADDR_W-1:0] >= {{(ADDR_W-LW){1'b0}}, limit_q}) begin
            res_status <= ST_BAD;
          end else begin
            div_start <= 1'b1;
            state     <= S_FREE_DIV;
          end
        end
        S_FREE_DIV: begin
          if (div_done) begin
            if (div_rem_zero) begin
              pcount[frame_idx] <= pcount_sel + 1'b1;
              total_parked      <= total_parked + 1'b1;
              res_index         <= div_quot[IW-1:0];
            end else begin
              res_status <= ST_BAD;
            end
            state <= S_DONE;
          end
        end
        S_REL_RD: begin
          if (!frame_ok) begin
            res_status <= ST_BAD;
            state      <= S_DONE;
          end else if (step_cnt == pcount_sel) begin
            pcount[frame_idx] <= '0;
            state             <= S_DONE;
          end else begin
            state <= S_REL_WR;
          end
        end
        S_REL_WR: begin
          used_count   <= used_minus1;
          total_parked <= total_parked - 1'b1;
          step_cnt     <= step_cnt + 1'b1;
          state        <= S_REL_RD;
        end
        S_INIT: begin
          if (step_cnt == cap_eff) begin
            used_count   <= '0;
            total_parked <= '0;
            for (int f = 0; f < FRAME_COUNT; f++) pcount[f] <= '0;
            state <= S_DONE;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_index  <= res_index;
            rsp_cpu    <= res_cpu;
            rsp_gpu    <= res_gpu;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.slot_index  = rsp_index;
  assign rsp.cpu_address = rsp_cpu;
  assign rsp.gpu_address = rsp_gpu;

  // checks
  `ASSERT_IMPL(a_parked_le_used, clk, rst, state == S_IDLE,
    total_parked <= used_count, "more slots parked than allocated")
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready,
    state != S_IDLE, "controller stayed idle after a transaction")
  `ASSERT_IMPL(a_div_done_in_free, clk, rst, div_done,
    state == S_FREE_DIV, "divider finished outside a free")
  `ASSERT_IMPL(a_rsp_from_done, clk, rst, $rose(rsp_valid),
    $past(state) == S_DONE, "response loaded outside the done state")
endmodule
